// ===== sv/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// mma_pkg
// Shared widths, codes and defaults for the multichannel moving average.
// ----------------------------------------------------------------------------
package mma_pkg;

  // Defaults for top-level parameters
  localparam int unsigned WINDOW_LEN_DEF = 16;

  // Converter channel count; reads at or above it return zero
  localparam int NUM_CHANNELS = 8;

  // Field widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned CHAN_W   = 5;
  localparam int unsigned NUM_SLOTS = 3;

  // Stream word widths
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 16;

  // Action codes carried in tuser
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // Tracked converter channels and their slots
  localparam logic signed [CHAN_W-1:0] TRK_CH0 = 5'sd0;
  localparam logic signed [CHAN_W-1:0] TRK_CH1 = 5'sd1;
  localparam logic signed [CHAN_W-1:0] TRK_CH3 = 5'sd3;

  localparam int unsigned SLOT_CH0 = 0;
  localparam int unsigned SLOT_CH1 = 1;
  localparam int unsigned SLOT_CH3 = 2;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;

endpackage

// ===== sv/multichannel_moving_average.sv =====
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Boxcar moving average of converter channels 0, 1 and 3 with running sums.
// A read word passes through the stage register, then the result register,
// before its result appears on the master side. Throughput: one word per
// cycle, sample or read, limited only by master-side back-pressure.
// Reset clears sums, ring position, quadrature mode and history valid bits
// at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multichannel_moving_average
  import mma_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,    // quadrature_mode
  // slave side
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [9:0] sample_ch0, [19:10] sample_ch1, [29:20] sample_ch3,
  // [34:30] channel, [39:35] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                 s_axis_tuser_i, // [0] action
  // master side
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o  // [9:0] average, [15:10] zero
);

  localparam int unsigned AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  logic                      quad_q;
  logic [AW-1:0]             wp_q;
  logic                      s1_valid_q;
  logic                      s1_act_q;
  logic [AW-1:0]             s1_addr_q;
  sample_t                   s1_smp_q [NUM_SLOTS];
  logic signed [CHAN_W-1:0]  s1_chan_q;
  sum_t                      sums_q [NUM_SLOTS];
  logic                      m_valid_q;
  sample_t                   m_data_q;

  logic      accept;
  logic      out_free;
  logic      s1_adv;
  logic      s1_push;
  sample_t   in_smp [NUM_SLOTS];
  sample_t   old_smp [NUM_SLOTS];
  logic      wr_en [NUM_SLOTS];
  sum_t      sel_sum;
  logic      tracked;
  sample_t   mean;

  // input unpacking
  assign in_smp[SLOT_CH0] = s_axis_tdata_i[0 +: SAMPLE_W];
  assign in_smp[SLOT_CH1] = s_axis_tdata_i[SAMPLE_W +: SAMPLE_W];
  assign in_smp[SLOT_CH3] = s_axis_tdata_i[2*SAMPLE_W +: SAMPLE_W];

  // handshake: samples always leave the stage, reads need the result slot
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s1_adv          = s1_valid_q && ((s1_act_q == ACT_SAMPLE) || out_free);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_push         = s1_valid_q && (s1_act_q == ACT_SAMPLE);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_q <= 1'b0;
    end else if (cfg_we_i) begin
      quad_q <= cfg_wdata_i;
    end
  end

  // ring position and stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept && (s_axis_tuser_i == ACT_SAMPLE)) begin
        wp_q <= (wp_q == AW'(WINDOW_LEN - 1)) ? '0 : wp_q + 1'b1;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_act_q  <= s_axis_tuser_i;
      s1_addr_q <= wp_q;
      s1_chan_q <= s_axis_tdata_i[3*SAMPLE_W +: CHAN_W];
      for (int k = 0; k < NUM_SLOTS; k++) begin
        s1_smp_q[k] <= in_smp[k];
      end
    end
  end

  // per-channel history rings
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_hist
    if (g == SLOT_CH3) begin : g_frz
      assign wr_en[g] = s1_push && !quad_q;
    end else begin : g_run
      assign wr_en[g] = s1_push;
    end

    mma_history #(
      .WINDOW_LEN (WINDOW_LEN)
    ) u_hist (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .rd_en_i   (accept && (s_axis_tuser_i == ACT_SAMPLE)),
      .rd_addr_i (wp_q),
      .wr_en_i   (wr_en[g]),
      .wr_addr_i (s1_addr_q),
      .wr_data_i (s1_smp_q[g]),
      .rd_data_o (old_smp[g])
    );
  end

  // running sums: drop oldest, add newest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        sums_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (wr_en[k]) begin
          sums_q[k] <= sums_q[k] + SUM_W'(s1_smp_q[k]) - SUM_W'(old_smp[k]);
        end
      end
    end
  end

  // channel decode for reads
  always_comb begin
    sel_sum = '0;
    tracked = 1'b0;
    if (!s1_chan_q[CHAN_W-1] && (int'(s1_chan_q) < NUM_CHANNELS)) begin
      unique case (s1_chan_q)
        TRK_CH0: begin
          sel_sum = sums_q[SLOT_CH0];
          tracked = 1'b1;
        end
        TRK_CH1: begin
          sel_sum = sums_q[SLOT_CH1];
          tracked = 1'b1;
        end
        TRK_CH3: begin
          sel_sum = sums_q[SLOT_CH3];
          tracked = 1'b1;
        end
        default: begin
          sel_sum = '0;
          tracked = 1'b0;
        end
      endcase
    end
  end

  mma_mean #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_mean (
    .sum_i  (sel_sum),
    .mean_o (mean)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_adv && (s1_act_q == ACT_READ)) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (s1_act_q == ACT_READ)) begin
      m_data_q <= tracked ? mean : '0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - SAMPLE_W)'(0), m_data_q};

endmodule

// ===== sv/mma_history.sv =====
// ----------------------------------------------------------------------------
// mma_history
// Ring of past samples for one channel, with per-entry valid bits so that
// entries never written read as zero after reset. Registered read with
// write-to-read forwarding.
// ----------------------------------------------------------------------------
module mma_history
  import mma_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF,
  localparam int unsigned AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  sample_t       wr_data_i,
  output sample_t       rd_data_o
);

  sample_t                mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]  vld_q;
  sample_t                rd_q;

  // storage array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // registered read; a write to the same entry this cycle is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else if (vld_q[rd_addr_i]) begin
        rd_q <= mem[rd_addr_i];
      end else begin
        rd_q <= '0;
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== sv/mma_mean.sv =====
// ----------------------------------------------------------------------------
// mma_mean
// Rounded mean floor((2*sum + N) / (2N)) by multiplying with a rounded-up
// reciprocal of 2N; the shift is wide enough to be exact over the sum range.
// ----------------------------------------------------------------------------
module mma_mean
  import mma_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  sum_t    sum_i,
  output sample_t mean_o
);

  localparam int unsigned XW   = SUM_W + 2;
  localparam int unsigned DIV  = 2 * WINDOW_LEN;
  localparam int unsigned SH   = XW + $clog2(DIV);
  localparam longint unsigned RECIP_L = ((64'd1 << SH) + DIV - 1) / DIV;
  localparam logic [SH-1:0] RECIP = SH'(RECIP_L);

  logic [XW-1:0]    num;
  logic [XW+SH-1:0] prod;

  // numerator 2*sum + N
  assign num  = {1'b0, sum_i, 1'b0} + XW'(WINDOW_LEN);

  // quotient by reciprocal multiply
  assign prod = (XW + SH)'(num) * (XW + SH)'(RECIP);

  assign mean_o = prod[SH +: SAMPLE_W];

endmodule
